@@ rtl/core/bffa_pkg.sv @@
// package for the bitmap first-free allocator: field widths, codes, shared types
// depends on nothing; used by the interfaces and every module of the block
package bffa_pkg;

   localparam int MAX_ENTRIES_DEF = 1024;
   localparam int NUM_W           = 11;
   localparam int STATUS_W        = 2;
   localparam int WORD_W          = 32;
   localparam int BIT_W           = 5;

   localparam logic [NUM_W-1:0] LIMIT_RESET = 11'd1024;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_BAD  = 2'd2;

   // what the word scanner reports for one bitmap word
   typedef struct packed {
      logic             found;
      logic [BIT_W-1:0] pos;
      logic             last;
   } scan_result_type;

endpackage

@@ rtl/core/bffa_if.sv @@
// channel interfaces of the bitmap first-free allocator: request, response, csr write
// depends on bffa_pkg for the field widths
interface bffa_req_if;
   logic                          valid;
   logic                          ready;
   logic                          cmd;
   logic [bffa_pkg::NUM_W-1:0]    entry_number;

   modport source (output valid, output cmd, output entry_number, input ready);
   modport sink   (input valid, input cmd, input entry_number, output ready);
endinterface

interface bffa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bffa_pkg::NUM_W-1:0]    allocated_number;
   logic [bffa_pkg::STATUS_W-1:0] status;
   logic [bffa_pkg::NUM_W-1:0]    free_count;

   modport source (output valid, output allocated_number, output status,
                   output free_count, input ready);
   modport sink   (input valid, input allocated_number, input status,
                   input free_count, output ready);
endinterface

interface bffa_csr_if;
   logic                          valid;
   logic                          ready;
   logic [bffa_pkg::NUM_W-1:0]    data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/bitmap_first_free_allocator.sv @@
// First-fit bitmap allocator. After reset the block first zeroes its bitmap memory, one
// 32-bit word per cycle, and takes no request until that pass is done; csr writes are
// taken at any time. Unless the limit is zero, an allocate reads the bitmap one word per
// cycle from word 0 and checks each with a priority encoder, reading at most
// ceil(limit/32) words; a free reads and rewrites one word. The one-port-pair bitmap
// memory serves one request at a time. A finished result waits in the output register;
// the next request is taken once the previous result has been loaded there.
// Depends on bffa_pkg, bffa_if, bffa_map_ram and bffa_word_scan.
module bitmap_first_free_allocator #(
   parameter int MAX_ENTRIES = bffa_pkg::MAX_ENTRIES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   bffa_req_if.sink          req_bus,
   bffa_rsp_if.source        rsp_bus,
   bffa_csr_if.sink          csr_bus
);

   localparam int MAP_WORDS = (MAX_ENTRIES + 31) / 32;
   localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int CNT_W     = $clog2(MAX_ENTRIES + 1);
   localparam int W         = (CNT_W > bffa_pkg::NUM_W) ? CNT_W : bffa_pkg::NUM_W;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_CHECK = 2'd2;
   localparam logic [1:0] ST_RESP  = 2'd3;

   logic [1:0]                      state_ff, state_in;
   logic [AW-1:0]                   clr_ff, clr_in;
   logic [AW-1:0]                   word_ff, word_in;
   logic                            cmd_ff, cmd_in;
   logic [bffa_pkg::NUM_W-1:0]      num_ff, num_in;
   logic [W-1:0]                    total_ff, total_in;
   logic [bffa_pkg::NUM_W-1:0]      limit_ff, limit_in;
   logic [bffa_pkg::NUM_W-1:0]      got_ff, got_in;
   logic [bffa_pkg::STATUS_W-1:0]   stat_ff, stat_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [bffa_pkg::NUM_W-1:0]      rsp_num_ff, rsp_num_in;
   logic [bffa_pkg::STATUS_W-1:0]   rsp_stat_ff, rsp_stat_in;
   logic [bffa_pkg::NUM_W-1:0]      rsp_free_ff, rsp_free_in;

   logic [W-1:0]                    lim;
   logic [W-1:0]                    base;
   logic [W-1:0]                    rem;
   logic [W-1:0]                    got_w;
   logic [W-1:0]                    req_idx;
   logic [W-1:0]                    free_idx;
   logic [W-1:0]                    free_left;
   logic                            req_take;
   logic                            rsp_slot_free;
   logic                            free_bad;
   logic [bffa_pkg::WORD_W-1:0]     bit_sel;

   logic                            wr_en;
   logic [AW-1:0]                   wr_addr;
   logic [bffa_pkg::WORD_W-1:0]     wr_data;
   logic [AW-1:0]                   rd_addr;
   logic [bffa_pkg::WORD_W-1:0]     rd_data;
   bffa_pkg::scan_result_type       scan;

   bffa_map_ram #(
      .DEPTH (MAP_WORDS),
      .AW    (AW)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bffa_word_scan #(
      .W (W)
   ) u_word_scan (
      .word   (rd_data),
      .rem    (rem),
      .result (scan)
   );

   // effective limit: csr value clamped to capacity
   always_comb begin
      if (W'(limit_ff) > W'(MAX_ENTRIES)) begin
         lim = W'(MAX_ENTRIES);
      end else begin
         lim = W'(limit_ff);
      end
   end

   assign req_take      = req_bus.valid && (state_ff == ST_IDLE);
   assign rsp_slot_free = !rsp_valid_ff || rsp_bus.ready;

   assign base     = W'(word_ff) << bffa_pkg::BIT_W;
   assign rem      = lim - base;
   assign got_w    = base + W'(scan.pos) + W'(1);
   assign req_idx  = W'(req_bus.entry_number) - W'(1);
   assign free_idx = W'(num_ff) - W'(1);
   assign bit_sel  = 32'(1) << free_idx[bffa_pkg::BIT_W-1:0];
   assign free_bad = (num_ff == '0) || (W'(num_ff) > lim) || ((rd_data & bit_sel) == '0);
   assign free_left = (lim > total_ff) ? (lim - total_ff) : '0;

   always_comb begin
      case (state_ff)
         ST_IDLE: begin
            if (req_bus.cmd == bffa_pkg::CMD_ALLOC) begin
               rd_addr = '0;
            end else begin
               rd_addr = req_idx[AW+bffa_pkg::BIT_W-1:bffa_pkg::BIT_W];
            end
         end
         ST_CHECK: rd_addr = word_ff + AW'(1);
         default:  rd_addr = '0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      word_in      = word_ff;
      cmd_in       = cmd_ff;
      num_in       = num_ff;
      total_in     = total_ff;
      got_in       = got_ff;
      stat_in      = stat_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_num_in   = rsp_num_ff;
      rsp_stat_in  = rsp_stat_ff;
      rsp_free_in  = rsp_free_ff;
      wr_en        = 1'b0;
      wr_addr      = word_ff;
      wr_data      = rd_data;

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == AW'(MAP_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               cmd_in  = req_bus.cmd;
               num_in  = req_bus.entry_number;
               word_in = rd_addr;
               got_in  = '0;
               if ((req_bus.cmd == bffa_pkg::CMD_ALLOC) && (lim == '0)) begin
                  stat_in  = bffa_pkg::STAT_FULL;
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (cmd_ff == bffa_pkg::CMD_ALLOC) begin
               if (scan.found) begin
                  wr_en    = 1'b1;
                  wr_data  = rd_data | (32'(1) << scan.pos);
                  total_in = total_ff + W'(1);
                  got_in   = got_w[bffa_pkg::NUM_W-1:0];
                  stat_in  = bffa_pkg::STAT_OK;
                  state_in = ST_RESP;
               end else if (scan.last) begin
                  stat_in  = bffa_pkg::STAT_FULL;
                  state_in = ST_RESP;
               end else begin
                  // next word was already addressed this cycle
                  word_in = word_ff + AW'(1);
               end
            end else begin
               if (free_bad) begin
                  stat_in = bffa_pkg::STAT_BAD;
               end else begin
                  wr_en   = 1'b1;
                  wr_data = rd_data & ~bit_sel;
                  stat_in = bffa_pkg::STAT_OK;
                  if (total_ff != '0) begin
                     total_in = total_ff - W'(1);
                  end
               end
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_num_in   = got_ff;
               rsp_stat_in  = stat_ff;
               rsp_free_in  = free_left[bffa_pkg::NUM_W-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      limit_in = limit_ff;
      if (csr_bus.valid) begin
         limit_in = csr_bus.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         total_ff     <= '0;
         limit_ff     <= bffa_pkg::LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         total_ff     <= total_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      cmd_ff      <= cmd_in;
      num_ff      <= num_in;
      got_ff      <= got_in;
      stat_ff     <= stat_in;
      rsp_num_ff  <= rsp_num_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_free_ff <= rsp_free_in;
   end

   assign req_bus.ready            = (state_ff == ST_IDLE);
   assign csr_bus.ready            = 1'b1;
   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.allocated_number = rsp_num_ff;
   assign rsp_bus.status           = rsp_stat_ff;
   assign rsp_bus.free_count       = rsp_free_ff;

endmodule

@@ rtl/core/bffa_map_ram.sv @@
// bitmap storage: one write port, one read port with registered read data
// depends on bffa_pkg for the word width
module bffa_map_ram #(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [bffa_pkg::WORD_W-1:0] wr_data,
   input  logic [AW-1:0]               rd_addr,
   output logic [bffa_pkg::WORD_W-1:0] rd_data
);

   logic [bffa_pkg::WORD_W-1:0] mem [DEPTH];
   logic [bffa_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/bffa_word_scan.sv @@
// finds the lowest clear bit of one bitmap word below the entry limit
// depends on bffa_pkg for the word width and the scan result struct
module bffa_word_scan #(
   parameter int W = 11
) (
   input  logic [bffa_pkg::WORD_W-1:0] word,
   input  logic [W-1:0]                rem,
   output bffa_pkg::scan_result_type   result
);

   logic [bffa_pkg::WORD_W-1:0] mask;
   logic [bffa_pkg::WORD_W-1:0] cand;
   logic [bffa_pkg::BIT_W-1:0]  pos;

   // rem is the number of entries left from this word's first bit up to the limit
   always_comb begin
      if (rem >= W'(bffa_pkg::WORD_W)) begin
         mask = '1;
      end else begin
         mask = (32'(1) << rem[bffa_pkg::BIT_W-1:0]) - 32'(1);
      end
   end

   assign cand = ~word & mask;

   always_comb begin
      pos = '0;
      for (int j = bffa_pkg::WORD_W-1; j >= 0; j--) begin
         if (cand[j]) begin
            pos = bffa_pkg::BIT_W'(j);
         end
      end
   end

   assign result.found = |cand;
   assign result.pos   = pos;
   assign result.last  = (rem <= W'(bffa_pkg::WORD_W));

endmodule
